// ----- hdl/rme_pkg.sv -----
// Shared types and constants of the register machine execute unit.
package rme_pkg;

	localparam int DATA_W      = 64;
	localparam int HALF_W      = DATA_W / 2;
	localparam int REG_FIELD_W = 12;
	localparam int POS_W       = 12;
	localparam int NEXT_W      = 13;
	localparam int ACTION_W    = 5;

	localparam logic [DATA_W-1:0] RF_RESET_VALUE = {(DATA_W / 8){8'hF0}};
	localparam logic [NEXT_W-1:0] PROGRAM_DEPTH  = NEXT_W'(4096);

	typedef enum logic [ACTION_W-1:0] {
		OP_NOP   = 5'd0,
		OP_RET   = 5'd1,
		OP_PRINT = 5'd2,
		OP_ADDI  = 5'd3,
		OP_ORI   = 5'd4,
		OP_ANDI  = 5'd5,
		OP_XORI  = 5'd6,
		OP_ADD   = 5'd7,
		OP_OR    = 5'd8,
		OP_AND   = 5'd9,
		OP_XOR   = 5'd10,
		OP_SUB   = 5'd11,
		OP_MUL   = 5'd12,
		OP_REM   = 5'd13,
		OP_BNE   = 5'd14,
		OP_BLT   = 5'd15,
		OP_BEQ   = 5'd16,
		OP_BGE   = 5'd17
	} op_t;

	// Status of a multi-cycle arithmetic unit.
	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

endpackage

// ----- hdl/rme_regfile.sv -----
// Register file memory with two read ports, one write port and a clearing sweep after reset.
module rme_regfile
	import rme_pkg::*;
#(
	parameter int REG_COUNT = 4096,
	localparam int IDX_W = $clog2(REG_COUNT)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rd_en,
	input  logic [IDX_W-1:0]  rd_addr_a,
	input  logic [IDX_W-1:0]  rd_addr_b,
	output logic [DATA_W-1:0] rd_data_a,
	output logic [DATA_W-1:0] rd_data_b,
	input  logic              wr_en,
	input  logic [IDX_W-1:0]  wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	output logic              ready
);

	logic [DATA_W-1:0] mem_q [REG_COUNT];
	logic [DATA_W-1:0] rd_data_a_q;
	logic [DATA_W-1:0] rd_data_b_q;
	logic [IDX_W-1:0]  clr_q;
	logic              clearing_q;

	logic              mem_we;
	logic [IDX_W-1:0]  mem_waddr;
	logic [DATA_W-1:0] mem_wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= '0;
			clearing_q <= 1'b1;
		end else if (clearing_q) begin
			clr_q <= clr_q + IDX_W'(1);
			if (clr_q == IDX_W'(REG_COUNT - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// The sweep owns the write port until every entry holds the reset pattern.
	always_comb begin
		if (clearing_q) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = RF_RESET_VALUE;
		end else begin
			mem_we    = wr_en;
			mem_waddr = wr_addr;
			mem_wdata = wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		if (rd_en) begin
			rd_data_a_q <= mem_q[rd_addr_a];
			rd_data_b_q <= mem_q[rd_addr_b];
		end
	end

	assign rd_data_a = rd_data_a_q;
	assign rd_data_b = rd_data_b_q;
	assign ready     = !clearing_q;

endmodule

// ----- hdl/rme_mul.sv -----
// Multi-cycle 64 by 64 multiplier that returns the low 64 bits from three 32 by 32 products.
module rme_mul
	import rme_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DATA_W-1:0] a,
	input  logic [DATA_W-1:0] b,
	output logic [DATA_W-1:0] result,
	output unit_stat_t        stat
);

	logic [DATA_W-1:0] a_q;
	logic [DATA_W-1:0] b_q;
	logic [DATA_W-1:0] prod_q;
	logic [DATA_W-1:0] acc_q;
	logic [1:0]        step_q;
	logic              busy_q;
	logic              done_q;
	logic [HALF_W-1:0] mul_x;
	logic [HALF_W-1:0] mul_y;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			step_q <= '0;
		end else if (busy_q) begin
			step_q <= step_q + 2'd1;
			if (step_q == 2'd3) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Low times low first, then the two cross products; high times high falls off the top.
	always_comb begin
		case (step_q)
			2'd0: begin
				mul_x = a_q[HALF_W-1:0];
				mul_y = b_q[HALF_W-1:0];
			end
			2'd1: begin
				mul_x = a_q[HALF_W-1:0];
				mul_y = b_q[DATA_W-1:HALF_W];
			end
			default: begin
				mul_x = a_q[DATA_W-1:HALF_W];
				mul_y = b_q[HALF_W-1:0];
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
		end else if (busy_q) begin
			prod_q <= DATA_W'(mul_x) * DATA_W'(mul_y);
			if (step_q == 2'd1) begin
				acc_q <= prod_q;
			end else if (step_q != 2'd0) begin
				acc_q <= acc_q + {prod_q[HALF_W-1:0], {HALF_W{1'b0}}};
			end
		end
	end

	assign result    = acc_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ----- hdl/rme_div.sv -----
// Radix-2 restoring divider that returns the unsigned remainder, one bit per cycle.
module rme_div
	import rme_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DATA_W-1:0] a,
	input  logic [DATA_W-1:0] b,
	output logic [DATA_W-1:0] result,
	output unit_stat_t        stat
);

	localparam int CNT_W = $clog2(DATA_W);

	logic [DATA_W-1:0] dvd_q;
	logic [DATA_W-1:0] dvs_q;
	logic [DATA_W-1:0] rem_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DATA_W:0]   shifted;
	logic [DATA_W:0]   diff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + CNT_W'(1);
			if (cnt_q == CNT_W'(DATA_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// With a zero divisor the subtraction never borrows, so the remainder ends up as the
	// dividend itself.
	assign shifted = {rem_q, dvd_q[DATA_W-1]};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= a;
			dvs_q <= b;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[DATA_W-2:0], 1'b0};
			rem_q <= diff[DATA_W] ? shifted[DATA_W-1:0] : diff[DATA_W-1:0];
		end
	end

	assign result    = rem_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// ----- hdl/register_machine_execute_unit.sv -----
// Channel   Direction  Handshake               Payload
// input     in         in_valid / in_stall     action, dest_reg, src1_reg, src2_reg, immediate,
//                                              branch_target, target_known, position
// result    out        out_valid / out_stall   next_position, print_valid, print_value,
//                                              label_error, finished
// config    in         cfg_we                  cfg_wdata (program_length)
//
// An item is read from the register file in ST_READ and executed in ST_EXEC; mul and rem
// then wait in ST_WAIT for the shared 32 by 32 multiplier or the bit-serial divider.
// After reset a sweep writes the reset pattern into all REG_COUNT registers, one per cycle,
// and no input is taken until the sweep is done.
// A stalled result sits in the output register while the next item is already accepted;
// an item only waits at its write-back if the output register is still full and stalled.
module register_machine_execute_unit
	import rme_pkg::*;
#(
	parameter int REG_COUNT = 4096
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [NEXT_W-1:0]      cfg_wdata,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [ACTION_W-1:0]    action,
	input  logic [REG_FIELD_W-1:0] dest_reg,
	input  logic [REG_FIELD_W-1:0] src1_reg,
	input  logic [REG_FIELD_W-1:0] src2_reg,
	input  logic [DATA_W-1:0]      immediate,
	input  logic [POS_W-1:0]       branch_target,
	input  logic                   target_known,
	input  logic [POS_W-1:0]       position,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [NEXT_W-1:0]      next_position,
	output logic                   print_valid,
	output logic [DATA_W-1:0]      print_value,
	output logic                   label_error,
	output logic                   finished
);

	localparam int IDX_W = $clog2(REG_COUNT);
	localparam int RED_W = REG_FIELD_W + IDX_W + 1;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_READ = 4'b0010,
		ST_EXEC = 4'b0100,
		ST_WAIT = 4'b1000
	} state_t;

	// Folds a register field onto the register count by conditional subtraction of the
	// count shifted down from the top; a power-of-two count is a plain bit select.
	function automatic logic [IDX_W-1:0] reg_index(input logic [REG_FIELD_W-1:0] v);
		logic [RED_W-1:0] r;
		logic [RED_W-1:0] m;
		r = RED_W'(v);
		if ((REG_COUNT & (REG_COUNT - 1)) != 0) begin
			for (int k = REG_FIELD_W - 1; k >= 0; k--) begin
				m = RED_W'(REG_COUNT) << k;
				if (r >= m) begin
					r = r - m;
				end
			end
		end
		return r[IDX_W-1:0];
	endfunction

	state_t state_q;
	state_t state_d;

	logic [NEXT_W-1:0]      program_length_q;
	logic [ACTION_W-1:0]    action_q;
	logic [REG_FIELD_W-1:0] dest_reg_q;
	logic [REG_FIELD_W-1:0] src1_reg_q;
	logic [REG_FIELD_W-1:0] src2_reg_q;
	logic [DATA_W-1:0]      immediate_q;
	logic [POS_W-1:0]       branch_target_q;
	logic                   target_known_q;
	logic [POS_W-1:0]       position_q;

	logic                   out_valid_q;
	logic [NEXT_W-1:0]      next_position_q;
	logic                   print_valid_q;
	logic [DATA_W-1:0]      print_value_q;
	logic                   label_error_q;
	logic                   finished_q;

	logic                   rf_ready;
	logic                   rf_rd_en;
	logic [IDX_W-1:0]       rf_addr_a;
	logic [IDX_W-1:0]       rf_addr_b;
	logic [DATA_W-1:0]      rf_a;
	logic [DATA_W-1:0]      rf_b;
	logic                   rf_wr_en;
	logic [IDX_W-1:0]       rf_wr_addr;
	logic [DATA_W-1:0]      rf_wr_data;

	logic                   mul_start;
	logic                   div_start;
	logic [DATA_W-1:0]      mul_result;
	logic [DATA_W-1:0]      div_result;
	unit_stat_t             mul_stat;
	unit_stat_t             div_stat;

	op_t                    op;
	logic                   is_mul;
	logic                   is_rem;
	logic                   alu_wr;
	logic [DATA_W-1:0]      alu_val;
	logic                   taken;
	logic                   lerr;
	logic                   pvalid;
	logic [DATA_W-1:0]      pvalue;
	logic [NEXT_W-1:0]      next_pos;
	logic [NEXT_W-1:0]      limit;
	logic                   can_load;
	logic                   fin;
	logic                   in_xfer;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			program_length_q <= '0;
		end else if (cfg_we) begin
			program_length_q <= cfg_wdata;
		end
	end

	assign op     = op_t'(action_q);
	assign is_mul = (op == OP_MUL);
	assign is_rem = (op == OP_REM);

	// Operand reads: print reads its register on the first port.
	assign rf_rd_en  = (state_q == ST_READ);
	assign rf_addr_a = reg_index((op == OP_PRINT) ? dest_reg_q : src1_reg_q);
	assign rf_addr_b = reg_index(src2_reg_q);

	rme_regfile #(
		.REG_COUNT(REG_COUNT)
	) u_regfile (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (rf_rd_en),
		.rd_addr_a (rf_addr_a),
		.rd_addr_b (rf_addr_b),
		.rd_data_a (rf_a),
		.rd_data_b (rf_b),
		.wr_en     (rf_wr_en),
		.wr_addr   (rf_wr_addr),
		.wr_data   (rf_wr_data),
		.ready     (rf_ready)
	);

	assign mul_start = (state_q == ST_EXEC) && is_mul;
	assign div_start = (state_q == ST_EXEC) && is_rem;

	rme_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (rf_a),
		.b      (rf_b),
		.result (mul_result),
		.stat   (mul_stat)
	);

	rme_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.a      (rf_a),
		.b      (rf_b),
		.result (div_result),
		.stat   (div_stat)
	);

	always_comb begin
		alu_val  = '0;
		alu_wr   = 1'b0;
		taken    = 1'b0;
		lerr     = 1'b0;
		pvalid   = 1'b0;
		pvalue   = '0;
		next_pos = {1'b0, position_q} + NEXT_W'(1);
		case (op)
			OP_PRINT: begin
				pvalid = 1'b1;
				pvalue = rf_a;
			end
			OP_ADDI: begin
				alu_val = rf_a + immediate_q;
				alu_wr  = 1'b1;
			end
			OP_ORI: begin
				alu_val = rf_a | immediate_q;
				alu_wr  = 1'b1;
			end
			OP_ANDI: begin
				alu_val = rf_a & immediate_q;
				alu_wr  = 1'b1;
			end
			OP_XORI: begin
				alu_val = rf_a ^ immediate_q;
				alu_wr  = 1'b1;
			end
			OP_ADD: begin
				alu_val = rf_a + rf_b;
				alu_wr  = 1'b1;
			end
			OP_OR: begin
				alu_val = rf_a | rf_b;
				alu_wr  = 1'b1;
			end
			OP_AND: begin
				alu_val = rf_a & rf_b;
				alu_wr  = 1'b1;
			end
			OP_XOR: begin
				alu_val = rf_a ^ rf_b;
				alu_wr  = 1'b1;
			end
			OP_SUB: begin
				alu_val = rf_a - rf_b;
				alu_wr  = 1'b1;
			end
			OP_BNE, OP_BLT, OP_BEQ, OP_BGE: begin
				// An undefined label halts at this instruction whatever the comparison says.
				if (!target_known_q) begin
					lerr     = 1'b1;
					next_pos = {1'b0, position_q};
				end else begin
					case (op)
						OP_BNE:  taken = (rf_a != rf_b);
						OP_BLT:  taken = (rf_a < rf_b);
						OP_BEQ:  taken = (rf_a == rf_b);
						default: taken = (rf_a >= rf_b);
					endcase
					if (taken) begin
						next_pos = {1'b0, branch_target_q};
					end
				end
			end
			default: begin
			end
		endcase
	end

	assign limit = (program_length_q > PROGRAM_DEPTH) ? PROGRAM_DEPTH : program_length_q;

	assign can_load = !out_valid_q || !out_stall;

	// The item completes when its result can enter the output register.
	assign fin = can_load && (((state_q == ST_EXEC) && !is_mul && !is_rem) ||
		((state_q == ST_WAIT) && is_mul && mul_stat.done) ||
		((state_q == ST_WAIT) && is_rem && div_stat.done));

	assign in_stall = !(((state_q == ST_IDLE) && rf_ready) || fin);
	assign in_xfer  = in_valid && !in_stall;

	assign rf_wr_en   = fin && (alu_wr || is_mul || is_rem);
	assign rf_wr_addr = reg_index(dest_reg_q);
	assign rf_wr_data = is_mul ? mul_result : (is_rem ? div_result : alu_val);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (is_mul || is_rem) begin
					state_d = ST_WAIT;
				end else if (fin) begin
					state_d = in_xfer ? ST_READ : ST_IDLE;
				end
			end
			ST_WAIT: begin
				if (fin) begin
					state_d = in_xfer ? ST_READ : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (fin) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			action_q        <= action;
			dest_reg_q      <= dest_reg;
			src1_reg_q      <= src1_reg;
			src2_reg_q      <= src2_reg;
			immediate_q     <= immediate;
			branch_target_q <= branch_target;
			target_known_q  <= target_known;
			position_q      <= position;
		end
		if (fin) begin
			next_position_q <= next_pos;
			print_valid_q   <= pvalid;
			print_value_q   <= pvalue;
			label_error_q   <= lerr;
			finished_q      <= lerr || (next_pos >= limit);
		end
	end

	assign out_valid     = out_valid_q;
	assign next_position = next_position_q;
	assign print_valid   = print_valid_q;
	assign print_value   = print_value_q;
	assign label_error   = label_error_q;
	assign finished      = finished_q;

`ifndef NO_ASSERTIONS
	// Register writes happen only together with the transfer of the result into the output.
	a_write_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		rf_wr_en |-> fin)
		else $error("register file written without a completing result");

	// No input is taken while an arithmetic unit still works on the current item.
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(mul_stat.busy || div_stat.busy) |-> in_stall)
		else $error("input accepted while the multiplier or divider is busy");

	// The clearing sweep must finish before any item reaches the register file.
	a_no_accept_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		!rf_ready |-> in_stall)
		else $error("input accepted during the register file clearing sweep");

	// A completed item always leaves a valid result behind.
	a_fin_loads_output: assert property (@(posedge clk) disable iff (!arst_n)
		fin |=> out_valid)
		else $error("completed item did not load the output register");
`endif

endmodule
